/* sv/bbp_pkg.sv */
// Shared types, constants and helpers for the bimodal branch predictor.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps

package bbp_pkg;

  // Fixed field widths
  localparam int ADDR_W       = 32;
  localparam int STAT_W       = 32;
  localparam int INDEX_BITS_W = 4;
  localparam int INIT_COUNT_W = 2;

  // Stream payload widths, padded to whole bytes
  localparam int IN_TDATA_W  = 40;
  localparam int OUT_TDATA_W = 168;

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 4;

  localparam logic [CFG_IDX_W-1:0] REG_INDEX_BITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_INIT_COUNT = 1'b1;

  localparam logic [INDEX_BITS_W-1:0] INDEX_BITS_RST = 4'd12;
  localparam logic [INIT_COUNT_W-1:0] INIT_COUNT_RST = 2'd0;

  typedef logic [STAT_W-1:0] stat_t;

  // Status passed from the back part to the front part
  typedef struct packed {
    logic                    clearing;
    logic [INDEX_BITS_W-1:0] index_bits;
  } bbp_status_t;

  // Increment that sticks at all ones
  function automatic stat_t sat_inc(input stat_t v);
    return (&v) ? v : stat_t'(v + 1'b1);
  endfunction

endpackage

/* sv/bbp_front.sv */
// Front part: accepts resolved branches and forms the table index.
// Depends on bbp_pkg; feeds bbp_fifo.
`timescale 1ns / 1ps

module bbp_front import bbp_pkg::*; #(
  parameter int MAX_INDEX_BITS = 12
) (
  input  logic                      in_tvalid,
  output logic                      in_tready,
  input  logic [IN_TDATA_W-1:0]     in_tdata,
  input  bbp_status_t               status,
  input  logic                      fifo_full,
  output logic                      push,
  output logic [MAX_INDEX_BITS-1:0] push_idx,
  output logic                      push_taken
);

  logic [4:0]                bits_eff;
  logic [MAX_INDEX_BITS-1:0] mask;

  // Hold off items while the table refills or the queue is full
  assign in_tready = !status.clearing && !fifo_full;
  assign push      = in_tvalid && in_tready;

  // Clamp the configured index width to the table size
  always_comb begin
    if ({1'b0, status.index_bits} > 5'(MAX_INDEX_BITS)) begin
      bits_eff = 5'(MAX_INDEX_BITS);
    end else begin
      bits_eff = {1'b0, status.index_bits};
    end
    for (int i = 0; i < MAX_INDEX_BITS; i++) begin
      mask[i] = (5'(i) < bits_eff);
    end
  end

  // Word index from the address, masked to the active width
  assign push_idx   = in_tdata[2 +: MAX_INDEX_BITS] & mask;
  assign push_taken = in_tdata[ADDR_W];

endmodule

/* sv/bbp_fifo.sv */
// Two-entry queue between the front and back parts of the predictor.
// Depends on bbp_pkg only for house consistency of imports.
`timescale 1ns / 1ps

module bbp_fifo import bbp_pkg::*; #(
  parameter int W = 13
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic [W-1:0] head_data,
  output logic         full,
  output logic         empty
);

  logic [W-1:0] slot_r [2];
  logic         wr_ptr_r;
  logic         wr_ptr_nxt;
  logic         rd_ptr_r;
  logic         rd_ptr_nxt;
  logic [1:0]   cnt_r;
  logic [1:0]   cnt_nxt;

  assign full      = (cnt_r == 2'd2);
  assign empty     = (cnt_r == 2'd0);
  assign head_data = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

/* sv/bbp_back.sv */
// Back part: counter table, refill sweep, statistics and result register.
// Depends on bbp_pkg; pops items from bbp_fifo.
`timescale 1ns / 1ps

module bbp_back import bbp_pkg::*; #(
  parameter int MAX_INDEX_BITS = 12,
  parameter int COUNTER_BITS   = 2
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [CFG_IDX_W-1:0]      cfg_index,
  input  logic [CFG_DATA_W-1:0]     cfg_wdata,
  output bbp_status_t               status,
  input  logic                      fifo_empty,
  input  logic [MAX_INDEX_BITS-1:0] head_idx,
  input  logic                      head_taken,
  output logic                      pop,
  output logic                      out_tvalid,
  input  logic                      out_tready,
  output logic [OUT_TDATA_W-1:0]    out_tdata
);

  localparam int TABLE_DEPTH = 1 << MAX_INDEX_BITS;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_UPD  = 2'b10
  } back_state_t;

  // Configuration
  logic [INDEX_BITS_W-1:0]   index_bits_r;
  logic [INIT_COUNT_W-1:0]   init_count_r;
  logic [7:0]                init_ext;
  logic [COUNTER_BITS-1:0]   init_val;

  // Refill sweep
  logic                      clr_active_r;
  logic                      clr_active_nxt;
  logic [MAX_INDEX_BITS-1:0] clr_addr_r;
  logic [MAX_INDEX_BITS-1:0] clr_addr_nxt;

  // Table
  logic [COUNTER_BITS-1:0]   table_mem [TABLE_DEPTH];
  logic [COUNTER_BITS-1:0]   ctr_q;
  logic                      mem_we;
  logic [MAX_INDEX_BITS-1:0] mem_waddr;
  logic [COUNTER_BITS-1:0]   mem_wdata;

  // Sequencer
  back_state_t               state_r;
  back_state_t               state_nxt;
  logic [MAX_INDEX_BITS-1:0] cur_idx_r;
  logic                      cur_taken_r;
  logic                      done;

  // Update math
  logic                      predict;
  logic                      correct;
  logic [COUNTER_BITS-1:0]   new_ctr;

  // Statistics and result
  stat_t                     total_r,  total_nxt;
  stat_t                     tk_tot_r, tk_tot_nxt;
  stat_t                     tk_hit_r, tk_hit_nxt;
  stat_t                     nt_tot_r, nt_tot_nxt;
  stat_t                     nt_hit_r, nt_hit_nxt;
  logic                      pred_r;
  logic                      corr_r;
  logic                      out_valid_r;
  logic                      out_valid_nxt;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      index_bits_r <= INDEX_BITS_RST;
      init_count_r <= INIT_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_INDEX_BITS: index_bits_r <= cfg_wdata[INDEX_BITS_W-1:0];
        REG_INIT_COUNT: init_count_r <= cfg_wdata[INIT_COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign init_ext = {6'b0, init_count_r};
  assign init_val = init_ext[COUNTER_BITS-1:0];

  assign status.clearing   = clr_active_r;
  assign status.index_bits = index_bits_r;

  // Restart the sweep on every write, advance one entry per cycle
  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    if (cfg_we) begin
      clr_active_nxt = 1'b1;
      clr_addr_nxt   = '0;
    end else if (clr_active_r) begin
      if (&clr_addr_r) begin
        clr_active_nxt = 1'b0;
      end else begin
        clr_addr_nxt = clr_addr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
    end
  end

  // Sequencer: read in IDLE, write back in UPD once the result slot frees
  always_comb begin
    state_nxt = state_r;
    pop       = 1'b0;
    done      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!fifo_empty && !clr_active_r) begin
          pop       = 1'b1;
          state_nxt = ST_UPD;
        end
      end
      ST_UPD: begin
        if (!out_valid_r || out_tready) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Latch the item being worked on
  always_ff @(posedge clk) begin
    if (pop) begin
      cur_idx_r   <= head_idx;
      cur_taken_r <= head_taken;
    end
  end

  // Saturating counter update
  always_comb begin
    predict = ctr_q[COUNTER_BITS-1];
    correct = (predict == cur_taken_r);
    if (cur_taken_r) begin
      new_ctr = (&ctr_q) ? ctr_q : ctr_q + 1'b1;
    end else begin
      new_ctr = (|ctr_q) ? ctr_q - 1'b1 : ctr_q;
    end
  end

  // Table port: sweep writes take priority
  assign mem_we    = clr_active_r || done;
  assign mem_waddr = clr_active_r ? clr_addr_r : cur_idx_r;
  assign mem_wdata = clr_active_r ? init_val : new_ctr;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      ctr_q <= table_mem[head_idx];
    end
  end

  // Statistics
  always_comb begin
    total_nxt  = total_r;
    tk_tot_nxt = tk_tot_r;
    tk_hit_nxt = tk_hit_r;
    nt_tot_nxt = nt_tot_r;
    nt_hit_nxt = nt_hit_r;
    if (done) begin
      total_nxt = sat_inc(total_r);
      if (cur_taken_r) begin
        tk_tot_nxt = sat_inc(tk_tot_r);
        if (correct) begin
          tk_hit_nxt = sat_inc(tk_hit_r);
        end
      end else begin
        nt_tot_nxt = sat_inc(nt_tot_r);
        if (correct) begin
          nt_hit_nxt = sat_inc(nt_hit_r);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r  <= '0;
      tk_tot_r <= '0;
      tk_hit_r <= '0;
      nt_tot_r <= '0;
      nt_hit_r <= '0;
    end else begin
      total_r  <= total_nxt;
      tk_tot_r <= tk_tot_nxt;
      tk_hit_r <= tk_hit_nxt;
      nt_tot_r <= nt_tot_nxt;
      nt_hit_r <= nt_hit_nxt;
    end
  end

  // Result register; counts hold while a result waits
  assign out_valid_nxt = done ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      pred_r <= predict;
      corr_r <= correct;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, nt_hit_r, nt_tot_r, tk_hit_r, tk_tot_r, total_r, corr_r, pred_r};

endmodule

/* sv/bimodal_branch_predictor.sv */
// Top level of the bimodal branch predictor.
// Depends on bbp_pkg, bbp_front, bbp_fifo and bbp_back.
`timescale 1ns / 1ps
//
// Usage:
//   in_* takes one resolved branch per item: its byte address and outcome.
//   out_* returns one item per branch: the prediction made before the
//   update, whether it was right, and five saturating counts that include
//   this branch.
//   cfg_* writes index_bits (index 0) or init_count (index 1);
//   every write refills the table with init_count and keeps the counts.
// Flow: an accepted item waits in the queue; the back part reads its counter
//   in IDLE and writes it back with the result in UPD, and pops no new item
//   until that read-modify-write through the table's single read and write port is done.
// Reset: counts clear, registers return to 12 and 0, and the table is
//   refilled by a sweep over all 2**MAX_INDEX_BITS entries (4096 by default) during
//   which in_tready stays low; each configuration write starts the same sweep.
// Stall: while out_tready is low the result holds, the back part waits, and
//   the two-entry queue keeps in_tready high until it fills.

module bimodal_branch_predictor import bbp_pkg::*; #(
  parameter int MAX_INDEX_BITS = 12,
  parameter int COUNTER_BITS   = 2
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // Fields from bit 0: branch_address[31:0], was_taken[32], zero pad
  input  logic                   in_tvalid,
  output logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // Fields from bit 0: predicted_taken, prediction_correct, total_branches,
  // taken_total, taken_hits, not_taken_total, not_taken_hits, zero pad
  output logic                   out_tvalid,
  input  logic                   out_tready,
  output logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

  localparam int QW = MAX_INDEX_BITS + 1;

  bbp_status_t               status;
  logic                      push;
  logic [MAX_INDEX_BITS-1:0] push_idx;
  logic                      push_taken;
  logic                      pop;
  logic [QW-1:0]             head_data;
  logic                      fifo_full;
  logic                      fifo_empty;

  bbp_front #(
    .MAX_INDEX_BITS(MAX_INDEX_BITS)
  ) u_front (
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .status    (status),
    .fifo_full (fifo_full),
    .push      (push),
    .push_idx  (push_idx),
    .push_taken(push_taken)
  );

  bbp_fifo #(
    .W(QW)
  ) u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_data({push_idx, push_taken}),
    .pop      (pop),
    .head_data(head_data),
    .full     (fifo_full),
    .empty    (fifo_empty)
  );

  bbp_back #(
    .MAX_INDEX_BITS(MAX_INDEX_BITS),
    .COUNTER_BITS  (COUNTER_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .status    (status),
    .fifo_empty(fifo_empty),
    .head_idx  (head_data[QW-1:1]),
    .head_taken(head_data[0]),
    .pop       (pop),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

endmodule

/* test/bbp_result_checker.sv */
// Result checker for the bimodal branch predictor: watches the branch, result and
// register write channels, predicts each result and compares it field by field.
// Depends on bbp_pkg for widths, register indexes and the statistics type.
`timescale 1ns / 1ps

module bbp_result_checker import bbp_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  input  logic                   in_tready,
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  input  logic                   out_tvalid,
  input  logic                   out_tready,
  input  logic [OUT_TDATA_W-1:0] out_tdata,
  input  logic                   cfg_we,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  output int                     pending_results,
  output int                     mismatch_count
);

  localparam int TABLE_BITS  = 12;
  localparam int TABLE_DEPTH = 1 << TABLE_BITS;
  localparam int CTR_BITS    = 2;
  localparam logic [CTR_BITS-1:0] CTR_MAX  = '1;
  localparam logic [CTR_BITS-1:0] CTR_HALF = 2'b10;

  typedef struct packed {
    logic  predicted_taken;
    logic  prediction_correct;
    stat_t total_branches;
    stat_t taken_total;
    stat_t taken_hits;
    stat_t not_taken_total;
    stat_t not_taken_hits;
  } branch_outcome_t;

  // Predictor state: registers, counter table and running statistics
  logic [INDEX_BITS_W-1:0] index_bits_q;
  logic [INIT_COUNT_W-1:0] init_count_q;
  logic [CTR_BITS-1:0]     ctr_table [TABLE_DEPTH];
  stat_t                   n_total;
  stat_t                   n_taken;
  stat_t                   n_taken_hit;
  stat_t                   n_not_taken;
  stat_t                   n_not_taken_hit;
  branch_outcome_t         outcome_q [$];

  function automatic stat_t bump(input stat_t v);
    return (v == '1) ? v : v + stat_t'(1);
  endfunction

  task automatic refill_table();
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      ctr_table[i] = CTR_BITS'(init_count_q);
    end
  endtask

  // Look up the counter, predict, then train the counter and the statistics
  task automatic resolve_branch(input logic [ADDR_W-1:0] addr, input logic taken,
                                output branch_outcome_t r);
    int unsigned           width;
    logic [TABLE_BITS-1:0] slot;
    logic [CTR_BITS-1:0]   ctr;
    width = (index_bits_q > TABLE_BITS) ? TABLE_BITS : index_bits_q;
    slot = TABLE_BITS'((addr >> 2) & ((32'd1 << width) - 32'd1));
    ctr = ctr_table[slot];
    r.predicted_taken = (ctr >= CTR_HALF);
    r.prediction_correct = (r.predicted_taken == taken);
    n_total = bump(n_total);
    if (taken) begin
      n_taken = bump(n_taken);
      if (r.prediction_correct) n_taken_hit = bump(n_taken_hit);
      if (ctr != CTR_MAX) ctr = ctr + 1'b1;
    end else begin
      n_not_taken = bump(n_not_taken);
      if (r.prediction_correct) n_not_taken_hit = bump(n_not_taken_hit);
      if (ctr != '0) ctr = ctr - 1'b1;
    end
    ctr_table[slot] = ctr;
    r.total_branches  = n_total;
    r.taken_total     = n_taken;
    r.taken_hits      = n_taken_hit;
    r.not_taken_total = n_not_taken;
    r.not_taken_hits  = n_not_taken_hit;
  endtask

  task automatic check_field(input string name, input stat_t want, input stat_t got);
    if (want !== got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  // Track register writes, retire results against the oldest prediction, queue new ones
  always @(posedge clk) begin : watch_channels
    branch_outcome_t want;
    if (!rst_n) begin
      index_bits_q    = INDEX_BITS_RST;
      init_count_q    = INIT_COUNT_RST;
      refill_table();
      n_total         = '0;
      n_taken         = '0;
      n_taken_hit     = '0;
      n_not_taken     = '0;
      n_not_taken_hit = '0;
      outcome_q.delete();
      mismatch_count  = 0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_INDEX_BITS) begin
          index_bits_q = cfg_wdata[INDEX_BITS_W-1:0];
          refill_table();
        end else if (cfg_index == REG_INIT_COUNT) begin
          init_count_q = cfg_wdata[INIT_COUNT_W-1:0];
          refill_table();
        end
      end
      if (out_tvalid && out_tready) begin
        if (outcome_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %0h", $time, out_tdata);
          mismatch_count++;
        end else begin
          want = outcome_q.pop_front();
          check_field("predicted_taken", stat_t'(want.predicted_taken),
                      stat_t'(out_tdata[0]));
          check_field("prediction_correct", stat_t'(want.prediction_correct),
                      stat_t'(out_tdata[1]));
          check_field("total_branches", want.total_branches, out_tdata[33:2]);
          check_field("taken_total", want.taken_total, out_tdata[65:34]);
          check_field("taken_hits", want.taken_hits, out_tdata[97:66]);
          check_field("not_taken_total", want.not_taken_total, out_tdata[129:98]);
          check_field("not_taken_hits", want.not_taken_hits, out_tdata[161:130]);
        end
      end
      if (in_tvalid && in_tready) begin
        resolve_branch(in_tdata[ADDR_W-1:0], in_tdata[ADDR_W], want);
        outcome_q.push_back(want);
      end
    end
    pending_results <= outcome_q.size();
  end

endmodule

/* test/bimodal_branch_predictor_tb.sv */
// Testbench top for the bimodal branch predictor: drives branches, register writes
// and result back-pressure, and reports the verdict from bbp_result_checker.
// Depends on bbp_pkg, bimodal_branch_predictor and bbp_result_checker.
`timescale 1ns / 1ps

module bimodal_branch_predictor_tb;
  import bbp_pkg::*;

  localparam int CLK_HALF     = 4;
  localparam int LIMIT_CYCLES = 500000;
  localparam int PHASE_ITEMS  = 200;
  localparam int HOT_COUNT    = 8;

  logic                   clk        = 1'b0;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic                   out_tready = 1'b0;
  logic                   cfg_we     = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index  = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata  = '0;
  wire                    in_tready;
  wire                    out_tvalid;
  wire  [OUT_TDATA_W-1:0] out_tdata;
  int                     pending_results;
  int                     mismatch_count;

  int                     cycle_count     = 0;
  int unsigned            stall_left      = 0;
  int unsigned            calm_ready_left = 0;
  bit                     calm_send       = 1'b0;
  logic [ADDR_W-1:0]      hot_addr [HOT_COUNT];
  int unsigned            hot_bias [HOT_COUNT];

  bimodal_branch_predictor i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  bbp_result_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .pending_results (pending_results),
    .mismatch_count  (mismatch_count)
  );

  always #(CLK_HALF) clk = ~clk;

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("bimodal_branch_predictor test failed");
      $finish;
    end
  end

  // Idle length: mostly short, a few long
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  // Back-pressure on results, with occasional stretches of steady ready
  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_tready <= 1'b0;
    end else if (calm_ready_left > 0) begin
      calm_ready_left--;
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 199) == 0) begin
      calm_ready_left = $urandom_range(50, 300);
      out_tready <= 1'b1;
    end else if ($urandom_range(0, 99) < 70) begin
      out_tready <= 1'b1;
    end else begin
      stall_left = gap_len() - 1;
      out_tready <= 1'b0;
    end
  end

  // Offer one branch after a random gap and hold it until accepted
  task automatic send_branch(input logic [ADDR_W-1:0] addr, input logic taken);
    int unsigned gap;
    gap = calm_send ? 0 : (($urandom_range(0, 99) < 55) ? 0 : gap_len());
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= IN_TDATA_W'({taken, addr});
    do @(posedge clk); while (!in_tready);
  endtask

  // Wait out a table refill sweep
  task automatic settle_ready();
    repeat (4) @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // Stop sending and wait for every outstanding result
  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settle_ready();
  endtask

  // Reprogram while idle, then mostly train a small pool of hot branches
  task automatic run_phase(input bit wr_bits, input logic [CFG_DATA_W-1:0] bits_val,
                           input bit wr_init, input logic [CFG_DATA_W-1:0] init_val,
                           input int n_items);
    int          i;
    int unsigned k;
    drain_results();
    if (wr_bits) write_reg(REG_INDEX_BITS, bits_val);
    if (wr_init) write_reg(REG_INIT_COUNT, init_val);
    for (k = 0; k < HOT_COUNT; k++) begin
      if (k > 0 && $urandom_range(0, 3) == 0) begin
        // alias an earlier branch: same index bits, different upper bits
        hot_addr[k] = ($urandom & 32'hFFFF_C000) | (hot_addr[0] & 32'h0000_3FFF);
      end else begin
        hot_addr[k] = $urandom;
      end
      case ($urandom_range(0, 4))
        0:       hot_bias[k] = 0;
        1:       hot_bias[k] = 100;
        2:       hot_bias[k] = 90;
        3:       hot_bias[k] = 10;
        default: hot_bias[k] = 50;
      endcase
    end
    for (i = 0; i < n_items; i++) begin
      if (i % 64 == 0) calm_send = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 149) == 0) drain_results();
      if ($urandom_range(0, 99) < 85) begin
        k = $urandom_range(0, HOT_COUNT - 1);
        send_branch(hot_addr[k], $urandom_range(0, 99) < hot_bias[k]);
      end else begin
        send_branch($urandom, 1'($urandom_range(0, 1)));
      end
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    settle_ready();

    // Walk one counter up to saturation and back down to zero
    repeat (4) send_branch(32'h0000_1000, 1'b1);
    repeat (4) send_branch(32'h0000_1000, 1'b0);
    repeat (2) send_branch(32'h0000_1000, 1'b1);
    // Aliased address shares the trained counter; low two bits are ignored
    send_branch(32'hFFFF_D003, 1'b1);
    send_branch(32'hFFFF_D003, 1'b0);
    send_branch(32'h0000_1001, 1'b1);
    // Address extremes
    send_branch(32'h0000_0000, 1'b1);
    send_branch(32'hFFFF_FFFF, 1'b0);
    send_branch(32'hFFFF_FFFF, 1'b1);
    send_branch(32'h0000_0000, 1'b0);

    // Settings: zero index width, oversize width, wide init values, same-value refill
    run_phase(1'b0, 4'd0,  1'b0, 4'd0,     PHASE_ITEMS);
    run_phase(1'b1, 4'd0,  1'b1, 4'b0011,  PHASE_ITEMS);
    run_phase(1'b1, 4'd15, 1'b1, 4'b1110,  PHASE_ITEMS);
    run_phase(1'b0, 4'd0,  1'b1, 4'b0101,  PHASE_ITEMS);
    run_phase(1'b1, 4'd1,  1'b1, 4'b1100,  PHASE_ITEMS);
    run_phase(1'b1, 4'd12, 1'b1, 4'd3,     PHASE_ITEMS);
    run_phase(1'b1, 4'd13, 1'b0, 4'd0,     PHASE_ITEMS);
    run_phase(1'b1, 4'd6,  1'b1, 4'd2,     PHASE_ITEMS);
    run_phase(1'b0, 4'd0,  1'b1, 4'd2,     PHASE_ITEMS);

    drain_results();
    repeat (10) @(posedge clk);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("bimodal_branch_predictor test passed");
    end else begin
      $display("bimodal_branch_predictor test failed");
    end
    $finish;
  end

endmodule
